>>> sv/tip_pkg.sv
`timescale 1ns / 1ps

package tip_pkg;

   // Fixed widths of the ports.
   localparam int CH_WIDTH       = 8;
   localparam int RADIX_WIDTH    = 6;
   localparam int RESULT_WIDTH   = 64;
   localparam int OFFSET_WIDTH   = 16;
   localparam int WIDE_WIDTH     = 32;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_WORD_LSB   = 2;

   // Defaults of the top-level parameters.
   localparam int DEF_VALUE_WIDTH = 64;
   localparam int DEF_COUNT_WIDTH = 16;

   // Register word indexes.
   localparam logic REG_RADIX = 1'b0;

   // Radix codes.
   localparam logic [RADIX_WIDTH-1:0] RADIX_AUTO    = 6'd0;
   localparam logic [RADIX_WIDTH-1:0] RADIX_INVALID = 6'd1;
   localparam logic [RADIX_WIDTH-1:0] RADIX_OCTAL   = 6'd8;
   localparam logic [RADIX_WIDTH-1:0] RADIX_DECIMAL = 6'd10;
   localparam logic [RADIX_WIDTH-1:0] RADIX_HEX     = 6'd16;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX     = 6'd36;
   localparam logic [RADIX_WIDTH-1:0] NOT_DIGIT     = 6'd63;

   // Character codes.
   localparam logic [CH_WIDTH-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_WIDTH-1:0] CH_TAB   = 8'h09;
   localparam logic [CH_WIDTH-1:0] CH_CR    = 8'h0D;
   localparam logic [CH_WIDTH-1:0] CH_LF    = 8'h0A;
   localparam logic [CH_WIDTH-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CH_WIDTH-1:0] CH_MINUS = 8'h2D;
   localparam logic [CH_WIDTH-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_WIDTH-1:0] CH_NINE  = 8'h39;
   localparam logic [CH_WIDTH-1:0] CH_LO_A  = 8'h61;
   localparam logic [CH_WIDTH-1:0] CH_LO_Z  = 8'h7A;
   localparam logic [CH_WIDTH-1:0] CH_UP_A  = 8'h41;
   localparam logic [CH_WIDTH-1:0] CH_UP_Z  = 8'h5A;
   localparam logic [CH_WIDTH-1:0] CH_LO_X  = 8'h78;
   localparam logic [CH_WIDTH-1:0] CH_UP_X  = 8'h58;
   localparam logic [CH_WIDTH-1:0] LETTER_BASE = 8'd10;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_BLANK,
      PH_SIGNED,
      PH_ZERO,
      PH_XSEEN,
      PH_DIGITS
   } phase_type;

   typedef struct packed {
      logic [RESULT_WIDTH-1:0] value;
      logic                    range_error;
      logic [OFFSET_WIDTH-1:0] end_offset;
      logic                    bad_base;
   } result_type;

   // Digit value of a character, case-insensitive; NOT_DIGIT for anything else.
   function automatic logic [RADIX_WIDTH-1:0] digit_of(input logic [CH_WIDTH-1:0] c);
      logic [RADIX_WIDTH-1:0] d;
      d = NOT_DIGIT;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = RADIX_WIDTH'(c - CH_ZERO);
      end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
         d = RADIX_WIDTH'(c - CH_LO_A + LETTER_BASE);
      end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
         d = RADIX_WIDTH'(c - CH_UP_A + LETTER_BASE);
      end
      return d;
   endfunction

endpackage

>>> sv/text_to_integer_parser.sv
`timescale 1ns / 1ps
// A result is registered into the result register, or into the skid stage while one waits, at the transfer
// of the character that ends the number (or, for an unsupported radix, of the start character).
// Throughput: one character per cycle while req_ready is high; the limit is the accumulate loop,
// a VALUE_WIDTH by 6 bit multiply, an add and a compare between the accumulator register and itself.
// Reset is synchronous and active high; it clears the radix register, the parser state
// and both result valid flags, so the block comes out of reset idle and waiting for a start.
module text_to_integer_parser
   import tip_pkg::*;
#(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   // Character input channel.
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [CH_WIDTH-1:0]       req_ch,
   input  logic                      req_start_req,
   // Result channel.
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [RESULT_WIDTH-1:0]   rsp_result_value,
   output logic                      rsp_range_error,
   output logic [OFFSET_WIDTH-1:0]   rsp_end_offset,
   output logic                      rsp_bad_base,
   // Configuration port.
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   // The product of the accumulator and a radix, plus one digit, needs this many bits.
   localparam int PROD_WIDTH = VALUE_WIDTH + RADIX_WIDTH + 1;
   // Magnitude of the most negative value; the positive limit is one below it.
   localparam logic [VALUE_WIDTH-1:0] LIMIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic [VALUE_WIDTH-1:0] VMAX  = ~LIMIT;
   localparam logic [RESULT_WIDTH-1:0] VMAX_EXT = RESULT_WIDTH'(signed'(VMAX));
   localparam logic [RESULT_WIDTH-1:0] VMIN_EXT = RESULT_WIDTH'(signed'(LIMIT));

   // ------------------------------------------------------------------
   // Configuration register. Software is to write it only while the parser is idle; the
   // block does not enforce this. It is sampled into the active radix on every start character.
   // ------------------------------------------------------------------
   logic [RADIX_WIDTH-1:0] radix_ff;
   logic                   csr_write;
   logic                   csr_hit;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[CSR_WORD_LSB] == REG_RADIX);
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = csr_hit ? CSR_DATA_WIDTH'(radix_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_AUTO;
      end else if (csr_write && csr_hit) begin
         radix_ff <= pwdata[RADIX_WIDTH-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Parser state. Every accepted character moves it by one step.
   // ------------------------------------------------------------------
   phase_type              phase_ff, phase_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic                   neg_ff, neg_in;
   logic                   ovf_ff, ovf_in;
   logic [RADIX_WIDTH-1:0] act_radix_ff, act_radix_in;
   logic [COUNT_WIDTH-1:0] pos_ff, pos_in;

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   // A start character replaces the stored state with a fresh string.
   phase_type              cur_phase;
   logic [VALUE_WIDTH-1:0] cur_acc;
   logic                   cur_neg;
   logic                   cur_ovf;
   logic [RADIX_WIDTH-1:0] cur_radix;
   logic [COUNT_WIDTH-1:0] cur_pos;
   logic                   start_bad;

   always_comb begin
      cur_phase = phase_ff;
      cur_acc   = acc_ff;
      cur_neg   = neg_ff;
      cur_ovf   = ovf_ff;
      cur_radix = act_radix_ff;
      cur_pos   = pos_ff;
      if (req_start_req) begin
         cur_phase = PH_BLANK;
         cur_acc   = '0;
         cur_neg   = 1'b0;
         cur_ovf   = 1'b0;
         cur_radix = radix_ff;
         cur_pos   = '0;
      end
   end

   assign start_bad = req_start_req && (radix_ff == RADIX_INVALID || radix_ff > RADIX_MAX);

   // Character classification and the saturating position counter.
   logic [RADIX_WIDTH-1:0] digit;
   logic                   is_blank;
   logic                   is_sign;
   logic                   is_x;
   logic [COUNT_WIDTH-1:0] pos_adv;

   assign digit    = digit_of(req_ch);
   assign is_blank = (req_ch == CH_SPACE) || (req_ch == CH_TAB) ||
                     (req_ch == CH_CR) || (req_ch == CH_LF);
   assign is_sign  = (req_ch == CH_PLUS) || (req_ch == CH_MINUS);
   assign is_x     = (req_ch == CH_LO_X) || (req_ch == CH_UP_X);
   assign pos_adv  = (cur_pos == '1) ? cur_pos : cur_pos + 1'b1;

   // Accumulate unit: acc * radix + digit, with an exact check against the
   // magnitude limit. A leading zero in detect mode resolves to octal here.
   logic [RADIX_WIDTH-1:0] mul_radix;
   logic [PROD_WIDTH-1:0]  acc_sum;
   logic                   acc_over;
   logic                   digit_ok;

   assign mul_radix = (cur_phase == PH_ZERO && cur_radix == RADIX_AUTO) ? RADIX_OCTAL
                                                                         : cur_radix;
   assign acc_sum   = PROD_WIDTH'(cur_acc) * PROD_WIDTH'(mul_radix) + PROD_WIDTH'(digit);
   assign acc_over  = acc_sum > PROD_WIDTH'(LIMIT);
   assign digit_ok  = digit < mul_radix;

   // Radix for a first digit: detect mode without a leading zero means decimal.
   logic [RADIX_WIDTH-1:0] lead_radix;
   assign lead_radix = (cur_radix == RADIX_AUTO) ? RADIX_DECIMAL : cur_radix;

   // Next-state logic and the result that a character ends with.
   logic                   do_lead;
   logic                   do_digits;
   logic                   emit;
   logic                   emit_bad;
   logic [VALUE_WIDTH-1:0] emit_mag;
   logic [COUNT_WIDTH-1:0] emit_end;

   always_comb begin
      phase_in     = cur_phase;
      acc_in       = cur_acc;
      neg_in       = cur_neg;
      ovf_in       = cur_ovf;
      act_radix_in = cur_radix;
      pos_in       = cur_pos;
      do_lead      = 1'b0;
      do_digits    = 1'b0;
      emit         = 1'b0;
      emit_bad     = 1'b0;
      emit_mag     = '0;
      emit_end     = '0;

      if (start_bad) begin
         phase_in = PH_IDLE;
         emit     = 1'b1;
         emit_bad = 1'b1;
      end else begin
         case (cur_phase)
            PH_BLANK: begin
               if (is_blank) begin
                  pos_in = pos_adv;
               end else if (is_sign) begin
                  neg_in   = (req_ch == CH_MINUS);
                  phase_in = PH_SIGNED;
                  pos_in   = pos_adv;
               end else begin
                  do_lead = 1'b1;
               end
            end
            PH_SIGNED: begin
               do_lead = 1'b1;
            end
            PH_ZERO: begin
               if (is_x) begin
                  act_radix_in = RADIX_HEX;
                  phase_in     = PH_XSEEN;
                  pos_in       = pos_adv;
               end else begin
                  act_radix_in = mul_radix;
                  acc_in       = '0;
                  phase_in     = PH_DIGITS;
                  do_digits    = 1'b1;
               end
            end
            PH_XSEEN: begin
               if (digit < RADIX_HEX) begin
                  acc_in   = VALUE_WIDTH'(digit);
                  phase_in = PH_DIGITS;
                  pos_in   = pos_adv;
               end else begin
                  // The zero before the x is the only digit.
                  emit     = 1'b1;
                  emit_end = cur_pos - 1'b1;
               end
            end
            PH_DIGITS: begin
               do_digits = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         if (do_lead) begin
            if (req_ch == CH_ZERO &&
                (cur_radix == RADIX_AUTO || cur_radix == RADIX_HEX)) begin
               phase_in = PH_ZERO;
               pos_in   = pos_adv;
            end else begin
               act_radix_in = lead_radix;
               if (digit < lead_radix) begin
                  acc_in   = VALUE_WIDTH'(digit);
                  phase_in = PH_DIGITS;
                  pos_in   = pos_adv;
               end else begin
                  emit = 1'b1;
               end
            end
         end

         if (do_digits) begin
            if (digit_ok) begin
               if (!cur_ovf) begin
                  if (acc_over) begin
                     ovf_in = 1'b1;
                  end else begin
                     acc_in = acc_sum[VALUE_WIDTH-1:0];
                  end
               end
               pos_in = pos_adv;
            end else begin
               emit     = 1'b1;
               emit_mag = cur_acc;
               emit_end = cur_pos;
            end
         end

         if (emit) begin
            phase_in = PH_IDLE;
         end
      end
   end

   // Result formatting: clamp to the signed range and sign-extend.
   logic                   res_ovf;
   logic [VALUE_WIDTH-1:0] res_vw;
   logic [WIDE_WIDTH-1:0]  end_wide;
   result_type             res;

   always_comb begin
      res_ovf = cur_ovf || (!cur_neg && emit_mag[VALUE_WIDTH-1]);
      if (res_ovf) begin
         res_vw = cur_neg ? LIMIT : VMAX;
      end else begin
         res_vw = cur_neg ? (~emit_mag + 1'b1) : emit_mag;
      end
      end_wide = WIDE_WIDTH'(emit_end);
      if (emit_bad) begin
         res.value       = '0;
         res.range_error = 1'b0;
         res.end_offset  = '0;
         res.bad_base    = 1'b1;
      end else begin
         res.value       = RESULT_WIDTH'(signed'(res_vw));
         res.range_error = res_ovf;
         res.end_offset  = (end_wide > WIDE_WIDTH'({OFFSET_WIDTH{1'b1}})) ?
                           {OFFSET_WIDTH{1'b1}} : end_wide[OFFSET_WIDTH-1:0];
         res.bad_base    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         act_radix_ff <= RADIX_AUTO;
         pos_ff       <= '0;
      end else if (req_fire) begin
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         neg_ff       <= neg_in;
         ovf_ff       <= ovf_in;
         act_radix_ff <= act_radix_in;
         pos_ff       <= pos_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register with a skid stage behind it. The input keeps taking
   // characters while a result waits; only when a second result is parked
   // in the skid stage does req_ready drop.
   // ------------------------------------------------------------------
   logic       rsp_valid_ff, rsp_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       out_take;
   logic       new_res;

   assign out_take = rsp_valid_ff && rsp_ready;
   assign new_res  = req_fire && emit;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!rsp_valid_ff || out_take) begin
         rsp_valid_in = new_res;
         if (new_res) begin
            out_in = res;
         end
      end else if (new_res) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_ready        = !skid_valid_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = out_ff.value;
   assign rsp_range_error  = out_ff.range_error;
   assign rsp_end_offset   = out_ff.end_offset;
   assign rsp_bad_base     = out_ff.bad_base;

`ifndef NO_ASSERTIONS
   // The skid stage only fills behind a waiting result.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid stage holds a result while the result register is empty");

   // An unsupported radix gives an all-zero result apart from the flag.
   a_bad_base_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_base) |->
         (rsp_result_value == '0 && !rsp_range_error && rsp_end_offset == '0))
      else $error("bad_base result carries a nonzero field");

   // A range error always comes with a clamped value.
   a_range_clamped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |->
         (rsp_result_value == VMAX_EXT || rsp_result_value == VMIN_EXT))
      else $error("range error without a saturated value");

   // A start with an unsupported radix leaves the parser idle.
   a_bad_start_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_start_req && (radix_ff == RADIX_INVALID || radix_ff > RADIX_MAX))
         |=> (phase_ff == PH_IDLE))
      else $error("parser left idle after a start with an unsupported radix");

   // Overflow can only have happened while taking digits.
   a_ovf_phase: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (phase_ff == PH_DIGITS || phase_ff == PH_IDLE))
      else $error("overflow flag set outside of the digit phase");
`endif

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the streaming text-to-integer parser.
//
// A directed script walks the prefix, sign, blank and radix corner cases and
// the unsupported radix codes. After it, a series of random phases runs, each
// under one radix setting. Every character transfer is fed into a local model
// of the parser. Every result transfer is checked, field by field, against the
// oldest prediction.
module tb_top;
   import tip_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 1_000_000;
   localparam int unsigned DRAIN_CYCLES    = 4;
   localparam int unsigned HOLD_CYCLES     = 300;
   localparam int unsigned PHASE_ITEMS     = 80;
   localparam int unsigned SEND_IDLE_LIGHT = 24;
   localparam int unsigned RECV_IDLE_HEAVY = 78;
   localparam int unsigned DIGIT_NONE      = 99;

   localparam logic [RESULT_WIDTH-1:0]   MAG_LIMIT  = 64'h8000_0000_0000_0000;
   localparam logic [OFFSET_WIDTH-1:0]   POS_MAX    = '1;
   localparam logic [CSR_ADDR_WIDTH-1:0] RADIX_ADDR =
      CSR_ADDR_WIDTH'(REG_RADIX) << CSR_WORD_LSB;

   // The directed script is a list of rows. A character row sends one character,
   // or the same character many times over. A radix row reprograms the radix.
   typedef enum logic {ROW_CHAR, ROW_RADIX} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic                    start;
      logic [CH_WIDTH-1:0]     ch;
      int unsigned             reps;
      bit                      typed;
      result_type              hand;
      logic [RADIX_WIDTH-1:0]  radix;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;

   logic                      req_valid;
   logic                      req_ready;
   logic [CH_WIDTH-1:0]       req_ch;
   logic                      req_start_req;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [RESULT_WIDTH-1:0]   rsp_result_value;
   logic                      rsp_range_error;
   logic [OFFSET_WIDTH-1:0]   rsp_end_offset;
   logic                      rsp_bad_base;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   text_to_integer_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ch           (req_ch),
      .req_start_req    (req_start_req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_range_error  (rsp_range_error),
      .rsp_end_offset   (rsp_end_offset),
      .rsp_bad_base     (rsp_bad_base),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #5 clock = ~clock;

   // Local copy of the parser state. It is updated at each character transfer.
   logic [RADIX_WIDTH-1:0]  csr_radix = RADIX_AUTO;
   phase_type               ps_phase  = PH_IDLE;
   logic [RESULT_WIDTH-1:0] ps_acc    = '0;
   logic                    ps_neg    = 1'b0;
   logic                    ps_ovf    = 1'b0;
   logic [RADIX_WIDTH-1:0]  ps_radix  = RADIX_AUTO;
   logic [OFFSET_WIDTH-1:0] ps_pos    = '0;

   result_type     pending_results[$];
   script_row_type script[$];
   int unsigned    error_count     = 0;
   int unsigned    items_accepted  = 0;
   int unsigned    results_checked = 0;
   int unsigned    cycle_count     = 0;
   int unsigned    req_idle_pct    = 0;
   int unsigned    rsp_idle_pct    = 0;
   bit             hold_rsp        = 1'b0;
   logic [RADIX_WIDTH-1:0] radix_setting = RADIX_AUTO;

   // The hand-written result of a directed row. The sender sets it together
   // with the payload, so it stays valid until the character transfer.
   bit             hand_typed  = 1'b0;
   result_type     hand_result = '0;

   function automatic bit radix_unsupported(input logic [RADIX_WIDTH-1:0] r);
      return (r == RADIX_INVALID) || (r > RADIX_MAX);
   endfunction

   // Digit value of a character in any base up to 36. Both letter cases are accepted.
   function automatic int unsigned char_digit(input logic [CH_WIDTH-1:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
      if (c >= CH_LO_A && c <= CH_LO_Z) return int'(c - CH_LO_A) + int'(LETTER_BASE);
      if (c >= CH_UP_A && c <= CH_UP_Z) return int'(c - CH_UP_A) + int'(LETTER_BASE);
      return DIGIT_NONE;
   endfunction

   // The character for a digit. The case of a letter is picked at random.
   function automatic logic [CH_WIDTH-1:0] digit_char(input int unsigned d);
      if (d < int'(LETTER_BASE)) return CH_WIDTH'(int'(CH_ZERO) + d);
      if ($urandom_range(1)) return CH_WIDTH'(int'(CH_LO_A) + d - int'(LETTER_BASE));
      return CH_WIDTH'(int'(CH_UP_A) + d - int'(LETTER_BASE));
   endfunction

   // The counter of consumed characters sticks at its top value.
   function automatic void bump_pos();
      if (ps_pos != POS_MAX) ps_pos = ps_pos + 1'b1;
   endfunction

   // Closes the number. The magnitude is clamped to the signed range. One more
   // than the largest positive value is still exact when the sign is minus.
   function automatic bit close_number(input logic [RESULT_WIDTH-1:0] mag,
                                       input logic [OFFSET_WIDTH-1:0] endpos,
                                       output result_type r);
      logic ovf;
      ovf = ps_ovf;
      if (!ovf && !ps_neg && mag > MAG_LIMIT - 1) ovf = 1'b1;
      if (ovf) r.value = ps_neg ? MAG_LIMIT : MAG_LIMIT - 1;
      else     r.value = ps_neg ? -mag : mag;
      r.range_error = ovf;
      r.end_offset  = endpos;
      r.bad_base    = 1'b0;
      ps_phase      = PH_IDLE;
      return 1'b1;
   endfunction

   // Handles a character once the number already holds a digit. Overflow is
   // caught before the multiply would leave the range. The accumulator then
   // stops, but the digits are still counted.
   function automatic bit take_digit(input logic [CH_WIDTH-1:0] c, output result_type r);
      int unsigned d;
      d = char_digit(c);
      r = '0;
      if (d < ps_radix) begin
         if (!ps_ovf) begin
            if (ps_acc > (MAG_LIMIT - RESULT_WIDTH'(d)) / RESULT_WIDTH'(ps_radix)) begin
               ps_ovf = 1'b1;
            end else begin
               ps_acc = ps_acc * RESULT_WIDTH'(ps_radix) + RESULT_WIDTH'(d);
            end
         end
         bump_pos();
         return 1'b0;
      end
      return close_number(ps_acc, ps_pos, r);
   endfunction

   // Handles the first character after the blanks and the sign. A zero may
   // open a prefix when the radix is detected from the text or is hexadecimal.
   function automatic bit lead_char(input logic [CH_WIDTH-1:0] c, output result_type r);
      int unsigned d;
      r = '0;
      if (c == CH_ZERO && (ps_radix == RADIX_AUTO || ps_radix == RADIX_HEX)) begin
         ps_phase = PH_ZERO;
         bump_pos();
         return 1'b0;
      end
      if (ps_radix == RADIX_AUTO) ps_radix = RADIX_DECIMAL;
      d = char_digit(c);
      if (d < ps_radix) begin
         ps_acc   = RESULT_WIDTH'(d);
         ps_phase = PH_DIGITS;
         bump_pos();
         return 1'b0;
      end
      return close_number('0, '0, r);
   endfunction

   // Predicts the result of one character transfer. It returns 1 when the
   // character closes a number, and then r holds the result.
   function automatic bit parse_char(input logic s, input logic [CH_WIDTH-1:0] c,
                                     output result_type r);
      int unsigned d;
      r = '0;
      if (s) begin
         ps_phase = PH_BLANK;
         ps_acc   = '0;
         ps_neg   = 1'b0;
         ps_ovf   = 1'b0;
         ps_pos   = '0;
         ps_radix = csr_radix;
         if (radix_unsupported(csr_radix)) begin
            ps_phase   = PH_IDLE;
            r.bad_base = 1'b1;
            return 1'b1;
         end
      end
      case (ps_phase)
         PH_BLANK: begin
            if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
               bump_pos();
               return 1'b0;
            end
            if (c == CH_PLUS || c == CH_MINUS) begin
               ps_neg   = (c == CH_MINUS);
               ps_phase = PH_SIGNED;
               bump_pos();
               return 1'b0;
            end
            return lead_char(c, r);
         end
         PH_SIGNED: return lead_char(c, r);
         PH_ZERO: begin
            if (c == CH_LO_X || c == CH_UP_X) begin
               ps_radix = RADIX_HEX;
               ps_phase = PH_XSEEN;
               bump_pos();
               return 1'b0;
            end
            // A zero with no x after it is a digit in its own right. Under
            // detection it also selects octal.
            if (ps_radix == RADIX_AUTO) ps_radix = RADIX_OCTAL;
            ps_acc   = '0;
            ps_phase = PH_DIGITS;
            return take_digit(c, r);
         end
         PH_XSEEN: begin
            d = char_digit(c);
            if (d < RADIX_HEX) begin
               ps_acc   = RESULT_WIDTH'(d);
               ps_phase = PH_DIGITS;
               bump_pos();
               return 1'b0;
            end
            // The x is not taken. The number ends just after the leading zero.
            return close_number('0, ps_pos - 1'b1, r);
         end
         PH_DIGITS: return take_digit(c, r);
         default: begin
            ps_phase = PH_IDLE;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic void check_field(input string ctx, input string field,
                                       input logic [RESULT_WIDTH-1:0] want,
                                       input logic [RESULT_WIDTH-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s, %s mismatch: expected %h, actual %h",
                  $time, ctx, field, want, got);
      end
   endfunction

   function automatic void compare_result(input string ctx, input result_type want,
                                          input logic [RESULT_WIDTH-1:0] v,
                                          input logic rerr,
                                          input logic [OFFSET_WIDTH-1:0] off,
                                          input logic bad);
      check_field(ctx, "result_value", want.value, v);
      check_field(ctx, "range_error", RESULT_WIDTH'(want.range_error), RESULT_WIDTH'(rerr));
      check_field(ctx, "end_offset", RESULT_WIDTH'(want.end_offset), RESULT_WIDTH'(off));
      check_field(ctx, "bad_base", RESULT_WIDTH'(want.bad_base), RESULT_WIDTH'(bad));
   endfunction

   // Everything is sampled at the rising edge. The inputs change only at the
   // falling edge, so each value seen here is the one the design latches. A
   // register write is mirrored into the local radix copy. A character transfer
   // runs the model first, and then a result transfer is checked, so a result
   // can never overtake its own prediction.
   always @(posedge clock) begin
      result_type predicted;
      result_type oldest;
      if (!reset) begin
         if (psel && penable && pwrite && pready && paddr == RADIX_ADDR) begin
            csr_radix = pwdata[RADIX_WIDTH-1:0];
         end
         if (req_valid && req_ready) begin
            items_accepted++;
            if (parse_char(req_start_req, req_ch, predicted)) begin
               if (hand_typed) begin
                  compare_result("hand value vs model", hand_result, predicted.value,
                                 predicted.range_error, predicted.end_offset,
                                 predicted.bad_base);
                  pending_results.push_back(hand_result);
               end else begin
                  pending_results.push_back(predicted);
               end
            end else if (hand_typed) begin
               error_count++;
               $display("%0t: model gives no result where one was written by hand", $time);
            end
         end
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result transfer: value %h, offset %h, bad_base %b",
                        $time, rsp_result_value, rsp_end_offset, rsp_bad_base);
            end else begin
               oldest = pending_results.pop_front();
               compare_result("result", oldest, rsp_result_value, rsp_range_error,
                              rsp_end_offset, rsp_bad_base);
            end
         end
      end
   end

   // Watchdog. It stops a hung run well after the slowest correct run would end.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   // Result receiver. It drops ready at random, at the rate of the current mix.
   // When the sequence asks for back-pressure, it holds ready low for a long
   // stretch, counted here. The sender goes on offering characters in the
   // meantime, so the parser fills up and has to stall its input.
   initial begin
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Sends one character. This is entered at a falling edge and returns at
   // one. Before the transfer, the sender may idle for a few cycles. Valid stays
   // high after a transfer, so back-to-back characters need no extra
   // assignment in the same step.
   task automatic push_char(input logic s, input logic [CH_WIDTH-1:0] c,
                            input bit typed, input result_type hand);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_start_req <= s;
      req_ch        <= c;
      hand_typed     = typed;
      hand_result    = hand;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Reprograms the radix while nothing is in flight, then reads it back. The
   // wait also covers a character that ends no number.
   task automatic set_radix(input logic [RADIX_WIDTH-1:0] value);
      logic [CSR_DATA_WIDTH-1:0] readback;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= RADIX_ADDR;
      pwdata  <= CSR_DATA_WIDTH'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback[RADIX_WIDTH-1:0] !== value) begin
         error_count++;
         $display("%0t: radix readback mismatch: expected %0d, actual %0d",
                  $time, value, readback[RADIX_WIDTH-1:0]);
      end
      radix_setting = value;
   endtask

   function automatic void put_char(input logic s, input logic [CH_WIDTH-1:0] c);
      script_row_type row;
      row = '0;
      row.kind  = ROW_CHAR;
      row.start = s;
      row.ch    = c;
      row.reps  = 1;
      script.push_back(row);
   endfunction

   // A row whose result is plain to see. It is written out by hand.
   function automatic void put_end(input logic s, input logic [CH_WIDTH-1:0] c,
                                   input logic [RESULT_WIDTH-1:0] v,
                                   input logic [OFFSET_WIDTH-1:0] off, input logic bad);
      script_row_type row;
      row = '0;
      row.kind            = ROW_CHAR;
      row.start           = s;
      row.ch              = c;
      row.reps            = 1;
      row.typed           = 1'b1;
      row.hand.value      = v;
      row.hand.end_offset = off;
      row.hand.bad_base   = bad;
      script.push_back(row);
   endfunction

   function automatic void put_radix(input logic [RADIX_WIDTH-1:0] r);
      script_row_type row;
      row = '0;
      row.kind  = ROW_RADIX;
      row.radix = r;
      script.push_back(row);
   endfunction

   // Builds and sends one random string. Most strings are well formed: a few
   // blanks, a sign, a prefix that fits the radix, then digits. The digits are
   // sometimes short, sometimes right at the edge of the signed range,
   // sometimes far past it. Then comes a character that ends the number. The
   // rest is noise: random bytes, or a number without an end, which the next
   // start drops. Characters sent after a number has closed are ignored by the
   // parser, so they do not count.
   task automatic send_random_string(output int unsigned counted);
      logic [CH_WIDTH-1:0]     text[$];
      logic [CH_WIDTH-1:0]     digs[$];
      logic [RESULT_WIDTH-1:0] mag;
      logic [CH_WIDTH-1:0]     c;
      int unsigned             kind;
      int unsigned             base;
      bit                      complete;
      bit                      use_mag;
      text    = {};
      digs    = {};
      use_mag = 1'b0;
      kind    = $urandom_range(99);
      if (kind < 12) begin
         repeat ($urandom_range(1, 6)) text.push_back(CH_WIDTH'($urandom_range(255)));
      end else begin
         complete = (kind >= 20);
         repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(3))
               0: text.push_back(CH_SPACE);
               1: text.push_back(CH_TAB);
               2: text.push_back(CH_CR);
               default: text.push_back(CH_LF);
            endcase
         end
         case ($urandom_range(2))
            1: text.push_back(CH_PLUS);
            2: text.push_back(CH_MINUS);
            default: ;
         endcase
         base = radix_setting;
         if (radix_setting == RADIX_AUTO) begin
            case ($urandom_range(2))
               0: base = RADIX_DECIMAL;
               1: begin
                  text.push_back(CH_ZERO);
                  base = RADIX_OCTAL;
               end
               default: begin
                  text.push_back(CH_ZERO);
                  text.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
                  base = RADIX_HEX;
               end
            endcase
         end else if (radix_setting == RADIX_HEX && $urandom_range(1)) begin
            text.push_back(CH_ZERO);
            text.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
         end
         if (radix_unsupported(radix_setting)) base = RADIX_DECIMAL;
         case ($urandom_range(9))
            6, 7: begin
               mag     = MAG_LIMIT - 2 + RESULT_WIDTH'($urandom_range(4));
               use_mag = 1'b1;
            end
            8: begin
               mag     = {$urandom, $urandom};
               use_mag = 1'b1;
            end
            9: begin
               repeat ($urandom_range(14, 30))
                  text.push_back(digit_char($urandom_range(base - 1)));
            end
            default: begin
               repeat ($urandom_range(1, 6))
                  text.push_back(digit_char($urandom_range(base - 1)));
            end
         endcase
         if (use_mag) begin
            do begin
               digs.push_front(digit_char(int'(mag % RESULT_WIDTH'(base))));
               mag = mag / RESULT_WIDTH'(base);
            end while (mag != 0);
            text = {text, digs};
         end
         if (complete) begin
            do c = CH_WIDTH'($urandom_range(255)); while (char_digit(c) < base);
            text.push_back(c);
         end
      end
      foreach (text[i]) push_char(i == 0, text[i], 1'b0, '0);
      counted = radix_unsupported(radix_setting) ? 1 : text.size();
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 3)) push_char(1'b0, CH_WIDTH'($urandom_range(255)), 1'b0, '0);
      end
   endtask

   initial begin
      logic [RADIX_WIDTH-1:0] radix_plan[$];
      int unsigned            budget;
      int unsigned            counted;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_ch        = '0;
      req_start_req = 1'b0;
      rsp_ready     = 1'b0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // The directed script runs under the first idling mix. The radix starts
      // out as detect-from-prefix after reset.
      req_idle_pct = SEND_IDLE_LIGHT;
      rsp_idle_pct = RECV_IDLE_HEAVY;

      // A blank, a minus sign and two digits.
      put_char(1'b1, CH_SPACE);
      put_char(1'b0, CH_MINUS);
      put_char(1'b0, "1");
      put_char(1'b0, "2");
      put_end(1'b0, ";", -64'sd12, 16'd4, 1'b0);
      // Detected hex, with mixed-case digits.
      put_char(1'b1, CH_ZERO);
      put_char(1'b0, CH_LO_X);
      put_char(1'b0, "F");
      put_char(1'b0, "f");
      put_char(1'b0, "g");
      // A zero and an x with no hex digit after them: only the zero is consumed.
      put_char(1'b1, CH_ZERO);
      put_char(1'b0, CH_UP_X);
      put_end(1'b0, "z", '0, 16'd1, 1'b0);
      // A leading zero selects octal, so a nine ends the number.
      put_char(1'b1, CH_ZERO);
      put_char(1'b0, "7");
      put_char(1'b0, "9");
      // A lone sign and a NUL byte count as no digits at all.
      put_char(1'b1, CH_PLUS);
      put_end(1'b0, "!", '0, '0, 1'b0);
      put_end(1'b1, 8'h00, '0, '0, 1'b0);
      // A digit while idle is ignored.
      put_char(1'b0, "7");
      // A new start drops the open string without a result.
      put_char(1'b1, "1");
      put_char(1'b1, "3");
      put_char(1'b0, ":");
      // Unsupported radix codes give a result on the start character itself.
      put_radix(RADIX_INVALID);
      put_end(1'b1, "5", '0, '0, 1'b1);
      put_radix('1);
      put_end(1'b1, "a", '0, '0, 1'b1);
      // The widest base, with the top byte as the end character.
      put_radix(RADIX_MAX);
      put_char(1'b1, "Z");
      put_char(1'b0, "z");
      put_char(1'b0, 8'hFF);
      // A radix change mid-string takes effect only at the next start.
      put_radix(RADIX_AUTO);
      put_char(1'b1, "1");
      put_char(1'b0, "2");
      put_radix(6'd2);
      put_char(1'b0, "9");
      put_char(1'b0, ";");
      put_char(1'b1, "1");
      put_char(1'b0, "2");

      foreach (script[i]) begin
         if (script[i].kind == ROW_RADIX) begin
            set_radix(script[i].radix);
         end else begin
            repeat (script[i].reps) begin
               push_char(script[i].start, script[i].ch, script[i].typed, script[i].hand);
            end
         end
      end

      // Random phases, one radix setting each. The first third runs with a
      // lightly idling sender and a heavily stalling receiver, the second third
      // the other way round, and the last third with no idling at all.
      radix_plan = '{RADIX_AUTO, RADIX_DECIMAL, RADIX_HEX, RADIX_OCTAL, 6'd2, RADIX_MAX,
                     RADIX_INVALID, RADIX_AUTO, RADIX_HEX, 6'(RADIX_MAX + 1), RADIX_DECIMAL,
                     6'd3, '1, RADIX_AUTO, 6'd7, RADIX_HEX, 6'(RADIX_MAX - 1), RADIX_AUTO};
      foreach (radix_plan[p]) begin
         if (p < 6) begin
            req_idle_pct = SEND_IDLE_LIGHT;
            rsp_idle_pct = RECV_IDLE_HEAVY;
         end else if (p < 12) begin
            req_idle_pct = RECV_IDLE_HEAVY;
            rsp_idle_pct = SEND_IDLE_LIGHT;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         set_radix(radix_plan[p]);
         if (p % 6 == 2) hold_rsp = 1'b1;
         budget = PHASE_ITEMS;
         while (budget > 0) begin
            send_random_string(counted);
            budget = (counted >= budget) ? 0 : budget - counted;
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Ran %0d character transfers and checked %0d result transfers,",
               items_accepted, results_checked);
      $display("over %0d radix settings and three idling mixes, each with one long stall.",
               radix_plan.size());
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches found", error_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
